// ----- src/fbal_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
// Holds the request/response payloads, status and kind codes and the sequencer states.
// No dependencies.
package fbal_pkg;

  localparam int unsigned KIND_W = 1;
  localparam int unsigned BLK_W  = 11;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned THR_W  = 11;
  localparam logic [THR_W-1:0] THR_RESET = 11'd1;
  // Heap size in blocks; the index and length fields above are sized for it.
  localparam int unsigned HEAP_BLOCKS = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_F_LOOK,
    S_F_SCAN,
    S_F_DEC,
    S_SHUP,
    S_SHDN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  request_blocks;
    logic [IDX_W-1:0]  release_index;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted_index;
    logic [BLK_W-1:0] granted_blocks;
  } rsp_t;

endpackage

// ----- src/fbal_if.sv -----
// Handshake channels of the allocator: request, response and configuration write.
// Depends on fbal_pkg for the payload types.
interface fbal_req_if
  import fbal_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fbal_rsp_if
  import fbal_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fbal_cfg_if
  import fbal_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/fbal_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module fbal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/fbal_ctrl.sv -----
// Request sequencer: scans, splits, inserts and merges entries of the segment table.
// Depends on fbal_pkg, the request and response interfaces and the two RAMs instantiated by the top.
module fbal_ctrl
  import fbal_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  fbal_req_if.sink                                   req_i,
  fbal_rsp_if.source                                 rsp_o,
  input  logic [THR_W-1:0]                           thr_i,
  output logic                                       seg_we_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0]            seg_waddr_o,
  output logic [$clog2(HEAP_BLOCKS)+$clog2(HEAP_BLOCKS+1)-1:0] seg_wdata_o,
  output logic                                       seg_re_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0]            seg_raddr_o,
  input  logic [$clog2(HEAP_BLOCKS)+$clog2(HEAP_BLOCKS+1)-1:0] seg_rdata_i,
  output logic                                       held_we_o,
  output logic [$clog2(HEAP_BLOCKS)-1:0]             held_waddr_o,
  output logic [$clog2(HEAP_BLOCKS+1):0]             held_wdata_o,
  output logic                                       held_re_o,
  output logic [$clog2(HEAP_BLOCKS)-1:0]             held_raddr_o,
  input  logic [$clog2(HEAP_BLOCKS+1):0]             held_rdata_i
);

  localparam int unsigned AW  = $clog2(HEAP_BLOCKS);
  localparam int unsigned LW  = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned SAW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW  = $clog2(MAX_SEGMENTS + 1);

  state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CW-1:0]    ptr_q, ptr_d, didx_q, didx_d, pos_q, pos_d, cnt_q, cnt_d;
  logic             dv_q, dv_d;
  logic [BLK_W-1:0] want_q, want_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [LW-1:0]    len_q, len_d;
  logic [AW-1:0]    prev_s_q, prev_s_d, nxt_s_q, nxt_s_d;
  logic [LW-1:0]    prev_l_q, prev_l_d, nxt_l_q, nxt_l_d;
  logic             prev_ok_q, prev_ok_d, nxt_ok_q, nxt_ok_d;
  rsp_t             res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [AW-1:0] seg_rs;
  logic [LW-1:0] seg_rl, a_diff, a_given;
  logic a_fit, a_whole, f_stop, ptr_lt, f_jn, f_jp, full, in_heap, out_free;

  assign seg_rs   = seg_rdata_i[AW+LW-1:LW];
  assign seg_rl   = seg_rdata_i[LW-1:0];
  assign a_fit    = 32'(seg_rl) >= 32'(want_q);
  assign a_diff   = seg_rl - LW'(want_q);
  assign a_whole  = 32'(a_diff) <= 32'(thr_i);
  assign a_given  = a_whole ? seg_rl : LW'(want_q);
  assign f_stop   = 32'(seg_rs) >= 32'(idx_q);
  assign ptr_lt   = ptr_q < cnt_q;
  assign f_jn     = nxt_ok_q && (32'(idx_q) + 32'(len_q) == 32'(nxt_s_q));
  assign f_jp     = prev_ok_q && (32'(prev_s_q) + 32'(prev_l_q) == 32'(idx_q));
  assign full     = cnt_q >= CW'(MAX_SEGMENTS);
  assign in_heap  = 32'(req_i.data.release_index) < HEAP_BLOCKS;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(HEAP_BLOCKS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.data.kind == KIND_ALLOC) begin
            state_d = (req_i.data.request_blocks == '0) ? S_DONE : S_A_SCAN;
          end else begin
            state_d = in_heap ? S_F_LOOK : S_DONE;
          end
        end
      end
      S_A_SCAN: begin
        if (dv_q && a_fit) begin
          state_d = a_whole ? S_SHDN : S_DONE;
        end else if (!ptr_lt) begin
          state_d = S_DONE;
        end
      end
      S_F_LOOK: begin
        state_d = held_rdata_i[LW] ? S_F_SCAN : S_DONE;
      end
      S_F_SCAN: begin
        if ((dv_q && f_stop) || !ptr_lt) state_d = S_F_DEC;
      end
      S_F_DEC: begin
        if (f_jn && f_jp)           state_d = S_SHDN;
        else if (f_jn || f_jp || full) state_d = S_DONE;
        else                        state_d = S_SHUP;
      end
      S_SHUP: begin
        if (!(ptr_q > pos_q) && !dv_q) state_d = S_DONE;
      end
      S_SHDN: begin
        if (!ptr_lt && !dv_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    clr_d = clr_q;  ptr_d = ptr_q;  didx_d = didx_q;  pos_d = pos_q;  cnt_d = cnt_q;
    dv_d = 1'b0;  want_d = want_q;  idx_d = idx_q;  len_d = len_q;
    prev_s_d = prev_s_q;  prev_l_d = prev_l_q;  prev_ok_d = prev_ok_q;
    nxt_s_d = nxt_s_q;  nxt_l_d = nxt_l_q;  nxt_ok_d = nxt_ok_q;
    res_d = res_q;  out_d = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    seg_we_o = 1'b0;  seg_waddr_o = '0;  seg_wdata_o = '0;
    seg_re_o = 1'b0;  seg_raddr_o = '0;
    held_we_o = 1'b0;  held_waddr_o = '0;  held_wdata_o = '0;
    held_re_o = 1'b0;  held_raddr_o = '0;
    case (state_q)
      S_CLEAR: begin
        held_we_o    = 1'b1;
        held_waddr_o = clr_q;
        if (clr_q == '0) begin
          seg_we_o    = 1'b1;
          seg_wdata_o = {AW'(0), LW'(HEAP_BLOCKS)};
        end
        clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (req_i.valid) begin
          want_d    = req_i.data.request_blocks;
          idx_d     = req_i.data.release_index;
          ptr_d     = '0;
          prev_ok_d = 1'b0;
          nxt_ok_d  = 1'b0;
          res_d.granted_index  = '0;
          res_d.granted_blocks = '0;
          res_d.status = (req_i.data.kind == KIND_ALLOC) ? ST_NOFIT : ST_BADADDR;
          held_re_o    = 1'b1;
          held_raddr_o = AW'(req_i.data.release_index);
        end
      end
      S_A_SCAN: begin
        if (ptr_lt && !(dv_q && a_fit)) begin
          seg_re_o    = 1'b1;
          seg_raddr_o = SAW'(ptr_q);
          ptr_d       = ptr_q + CW'(1);
          didx_d      = ptr_q;
          dv_d        = 1'b1;
        end
        if (dv_q && a_fit) begin
          held_we_o    = 1'b1;
          held_waddr_o = seg_rs;
          held_wdata_o = {1'b1, a_given};
          res_d.status         = ST_OK;
          res_d.granted_index  = IDX_W'(seg_rs);
          res_d.granted_blocks = BLK_W'(a_given);
          if (a_whole) begin
            // Whole segment goes away: close the gap behind it.
            ptr_d = didx_q + CW'(1);
          end else begin
            seg_we_o    = 1'b1;
            seg_waddr_o = SAW'(didx_q);
            seg_wdata_o = {seg_rs + AW'(want_q), a_diff};
          end
        end
      end
      S_F_LOOK: begin
        len_d = held_rdata_i[LW-1:0];
        ptr_d = '0;
      end
      S_F_SCAN: begin
        if (ptr_lt && !(dv_q && f_stop)) begin
          seg_re_o    = 1'b1;
          seg_raddr_o = SAW'(ptr_q);
          ptr_d       = ptr_q + CW'(1);
          didx_d      = ptr_q;
          dv_d        = 1'b1;
        end
        if (dv_q) begin
          if (f_stop) begin
            pos_d    = didx_q;
            nxt_s_d  = seg_rs;
            nxt_l_d  = seg_rl;
            nxt_ok_d = 1'b1;
          end else begin
            prev_s_d  = seg_rs;
            prev_l_d  = seg_rl;
            prev_ok_d = 1'b1;
          end
        end
        if (!ptr_lt && !(dv_q && f_stop)) pos_d = cnt_q;
      end
      S_F_DEC: begin
        if (f_jn || f_jp) begin
          held_we_o    = 1'b1;
          held_waddr_o = AW'(idx_q);
          res_d.status         = ST_OK;
          res_d.granted_blocks = BLK_W'(len_q);
          seg_we_o = 1'b1;
          if (f_jn && f_jp) begin
            seg_waddr_o = SAW'(pos_q - CW'(1));
            seg_wdata_o = {prev_s_q, prev_l_q + len_q + nxt_l_q};
            ptr_d       = pos_q + CW'(1);
          end else if (f_jn) begin
            seg_waddr_o = SAW'(pos_q);
            seg_wdata_o = {AW'(idx_q), len_q + nxt_l_q};
          end else begin
            seg_waddr_o = SAW'(pos_q - CW'(1));
            seg_wdata_o = {prev_s_q, prev_l_q + len_q};
          end
        end else if (full) begin
          res_d.status = ST_FULL;
        end else begin
          ptr_d = cnt_q;
        end
      end
      S_SHUP: begin
        if (ptr_q > pos_q) begin
          seg_re_o    = 1'b1;
          seg_raddr_o = SAW'(ptr_q - CW'(1));
          didx_d      = ptr_q;
          ptr_d       = ptr_q - CW'(1);
          dv_d        = 1'b1;
        end
        if (dv_q) begin
          seg_we_o    = 1'b1;
          seg_waddr_o = SAW'(didx_q);
          seg_wdata_o = seg_rdata_i;
        end else if (!(ptr_q > pos_q)) begin
          seg_we_o     = 1'b1;
          seg_waddr_o  = SAW'(pos_q);
          seg_wdata_o  = {AW'(idx_q), len_q};
          cnt_d        = cnt_q + CW'(1);
          held_we_o    = 1'b1;
          held_waddr_o = AW'(idx_q);
          res_d.status         = ST_OK;
          res_d.granted_blocks = BLK_W'(len_q);
        end
      end
      S_SHDN: begin
        if (ptr_lt) begin
          seg_re_o    = 1'b1;
          seg_raddr_o = SAW'(ptr_q);
          didx_d      = ptr_q;
          ptr_d       = ptr_q + CW'(1);
          dv_d        = 1'b1;
        end
        if (dv_q) begin
          seg_we_o    = 1'b1;
          seg_waddr_o = SAW'(didx_q - CW'(1));
          seg_wdata_o = seg_rdata_i;
        end else if (!ptr_lt) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= CW'(1);
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;  didx_q <= didx_d;  pos_q <= pos_d;
    want_q <= want_d;  idx_q <= idx_d;  len_q <= len_d;
    prev_s_q <= prev_s_d;  prev_l_q <= prev_l_d;  prev_ok_q <= prev_ok_d;
    nxt_s_q <= nxt_s_d;  nxt_l_q <= nxt_l_d;  nxt_ok_q <= nxt_ok_d;
    res_q <= res_d;  out_q <= out_d;
  end

  // The free-segment count never exceeds MAX_SEGMENTS; it reaches zero when the whole heap is handed out.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CW'(1) ||
                                  cnt_q + CW'(1) == $past(cnt_q)))
    else $error("segment count moved by more than one");

  a_no_req_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_grant_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SCAN && dv_q && a_fit) |->
      32'(a_given) >= 32'(want_q) && want_q != '0)
    else $error("grant smaller than request");

  a_seg_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_we_o && seg_re_o) |-> seg_waddr_o != seg_raddr_o)
    else $error("segment table read and write hit the same entry");

endmodule

// ----- src/first_fit_block_allocator.sv -----
// First-fit block allocator: one request at a time, result in an output register.
// Allocate scans the segment table for the first fit and closes up the entries behind
// a fully consumed segment; free scans to its place, then moves entries on an insert
// or merge. Both walks are set by the single read and write port of the segment table.
// Reset: a clearing pass over the allocation table; no request is taken meanwhile.
// Configuration writes are taken at any time.
module first_fit_block_allocator
  import fbal_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbal_req_if.sink   req_i,
  fbal_rsp_if.source rsp_o,
  fbal_cfg_if.sink   cfg_i
);

  localparam int unsigned AW  = $clog2(HEAP_BLOCKS);
  localparam int unsigned LW  = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned SAW = $clog2(MAX_SEGMENTS);

  logic [THR_W-1:0] thr_q;

  logic           seg_we, seg_re;
  logic [SAW-1:0] seg_waddr, seg_raddr;
  logic [AW+LW-1:0] seg_wdata, seg_rdata;
  logic           held_we, held_re;
  logic [AW-1:0]  held_waddr, held_raddr;
  logic [LW:0]    held_wdata, held_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  fbal_ram #(.WIDTH(AW + LW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .re_i    (seg_re),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  // Length granted to each allocated start block, with its valid bit on top.
  fbal_ram #(.WIDTH(LW + 1), .DEPTH(HEAP_BLOCKS)) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .waddr_i (held_waddr),
    .wdata_i (held_wdata),
    .re_i    (held_re),
    .raddr_i (held_raddr),
    .rdata_o (held_rdata)
  );

  fbal_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .thr_i        (thr_q),
    .seg_we_o     (seg_we),
    .seg_waddr_o  (seg_waddr),
    .seg_wdata_o  (seg_wdata),
    .seg_re_o     (seg_re),
    .seg_raddr_o  (seg_raddr),
    .seg_rdata_i  (seg_rdata),
    .held_we_o    (held_we),
    .held_waddr_o (held_waddr),
    .held_wdata_o (held_wdata),
    .held_re_o    (held_re),
    .held_raddr_o (held_raddr),
    .held_rdata_i (held_rdata)
  );

endmodule
